[sv/fpvm_pkg.sv]
// ============================================================================
// fpvm_pkg
// Shared widths, constants and types of the fixed-point vector magnitude block.
// ============================================================================
`default_nettype none

package fpvm_pkg;

    // component and product widths
    localparam int DATA_W        = 32;
    localparam int NUM_COMP      = 3;
    localparam int PROD_W        = 2 * DATA_W;

    // scaled square quotient and saturated sum
    localparam int QUOT_W        = 32;
    localparam int SUM_W         = 32;

    // square root
    localparam int ROOT_STEPS    = 16;
    localparam int ROOT_W        = ROOT_STEPS + 1;
    localparam logic [SUM_W-1:0] ROOT_TOP = 32'h4000_0000;

    // output scaling
    localparam int MAG_W         = 23;
    localparam int MAG_SCALE     = 100;
    localparam logic [MAG_W-1:0] MAX_MAG = 23'd6553600;

    // stream widths
    localparam int IN_TDATA_W    = NUM_COMP * DATA_W;
    localparam int OUT_TDATA_W   = ((MAG_W + 7) / 8) * 8;

    // default raw scale
    localparam int DEF_RESOLUTION = 10000;

    // one finished result
    typedef struct packed {
        logic             ovf;
        logic [MAG_W-1:0] mag;
    } fpvm_item_t;

endpackage

`default_nettype wire

[sv/fixed_point_vector_magnitude.sv]
// ============================================================================
// fixed_point_vector_magnitude
// Length of a three-component fixed-point vector at raw scale RESOLUTION:
// scaled squares, saturated sum, rounded integer square root, times 100.
// ============================================================================
//
//  channel  | dir | tdata fields (low bit up)                  | tuser
//  ---------+-----+--------------------------------------------+----------
//  s_*      | in  | comp_x[31:0], comp_y[63:32], comp_z[95:64] | -
//  m_*      | out | magnitude[22:0], zero pad[23]              | overflow
//
//  one transaction per cycle while the result buffer has room; 26 register
//  stages in all: six scaled square stages, the sum, 16 root steps,
//  rounding, scaling and the result buffer
//  reset clears all stage valid bits and the result buffer
//  stalls freeze the whole pipeline only once the two-entry result buffer
//  is full; s_tready depends on the buffer fill alone
//
`default_nettype none

module fixed_point_vector_magnitude #(
    parameter int RESOLUTION = fpvm_pkg::DEF_RESOLUTION
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fpvm_pkg::IN_TDATA_W-1:0]    s_tdata,   // comp_x, comp_y, comp_z
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [fpvm_pkg::OUT_TDATA_W-1:0]        m_tdata,   // magnitude, zero pad
    output logic                                    m_tuser    // overflow
);
    import fpvm_pkg::*;

    logic                     en;
    logic                     fifo_full;

    logic                     comp_valid [0:NUM_COMP-1];
    logic [QUOT_W-1:0]        comp_quot  [0:NUM_COMP-1];
    logic                     comp_ovf   [0:NUM_COMP-1];

    logic [SUM_W+1:0]         sum_wide;
    logic [SUM_W-1:0]         sum_next;
    logic                     sum_ovf_next;
    logic [SUM_W-1:0]         sum_reg;
    logic                     sum_ovf_reg;
    logic                     sum_valid_reg;

    logic                     root_valid;
    logic [ROOT_W-1:0]        root;
    logic                     root_ovf;

    logic [MAG_W-1:0]         mag_next;
    fpvm_item_t               mag_item_reg;
    logic                     mag_valid_reg;

    fpvm_item_t               out_item;

    // pipeline advances while the result buffer has room
    assign en       = !fifo_full;
    assign s_tready = en;

    // per-component scaled square
    for (genvar i = 0; i < NUM_COMP; i++)
    begin : g_comp
        fpvm_scale_sq #(
            .RESOLUTION (RESOLUTION)
        ) u_scale_sq (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s_tvalid),
            .comp      ($signed(s_tdata[i*DATA_W +: DATA_W])),
            .out_valid (comp_valid[i]),
            .quot      (comp_quot[i]),
            .ovf       (comp_ovf[i])
        );
    end

    // sum of quotients with saturation
    always_comb
    begin
        sum_wide     = {2'b00, comp_quot[0]} + {2'b00, comp_quot[1]} + {2'b00, comp_quot[2]};
        sum_ovf_next = comp_ovf[0] || comp_ovf[1] || comp_ovf[2] ||
                       (sum_wide[SUM_W+1:SUM_W] != 2'b00);
        sum_next     = sum_ovf_next ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg     <= sum_next;
            sum_ovf_reg <= sum_ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sum_valid_reg <= comp_valid[0];
        end
    end

    // rounded square root
    fpvm_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sum_valid_reg),
        .radicand  (sum_reg),
        .in_ovf    (sum_ovf_reg),
        .out_valid (root_valid),
        .root      (root),
        .out_ovf   (root_ovf)
    );

    // scale root back to raw units
    assign mag_next = MAG_W'(root) * MAG_W'(MAG_SCALE);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_item_reg.mag <= mag_next;
            mag_item_reg.ovf <= root_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mag_valid_reg <= root_valid;
        end
    end

    // result buffer
    fpvm_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && mag_valid_reg),
        .push_item (mag_item_reg),
        .full      (fifo_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = OUT_TDATA_W'(out_item.mag);
    assign m_tuser = out_item.ovf;

    // component pipelines stay in lockstep
    a_comp_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (comp_valid[0] == comp_valid[1]) && (comp_valid[0] == comp_valid[2]))
        else $error("component pipelines out of step");

    // a saturated sum always yields the largest magnitude
    a_ovf_mag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[MAG_W-1:0] == MAX_MAG)
        else $error("overflow result with wrong magnitude");

    // magnitude never exceeds its range
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[MAG_W-1:0] <= MAX_MAG)
        else $error("magnitude out of range");

    // input is held off only while results wait downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

endmodule

`default_nettype wire

[sv/fpvm_scale_sq.sv]
// ============================================================================
// fpvm_scale_sq
// Absolute value, square and truncating division by RESOLUTION of one
// component; the division is a reciprocal multiplication split into four
// partial products over three pipeline stages.
// ============================================================================
`default_nettype none

module fpvm_scale_sq #(
    parameter int RESOLUTION = fpvm_pkg::DEF_RESOLUTION
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [fpvm_pkg::DATA_W-1:0]  comp,
    output logic                                     out_valid,
    output logic [fpvm_pkg::QUOT_W-1:0]              quot,
    output logic                                     ovf
);
    import fpvm_pkg::*;

    localparam int RES_W = $clog2(RESOLUTION + 1);
    localparam int NUM_W = RES_W + QUOT_W;
    localparam logic [PROD_W-1:0] OVF_LIMIT = PROD_W'(RESOLUTION) << QUOT_W;

    // reciprocal ceil(2^RCP_SHIFT / RESOLUTION), exact for every NUM_W-bit numerator
    localparam int RCP_SHIFT = NUM_W + RES_W;
    localparam int POW_W     = RCP_SHIFT + 1;
    localparam int RCP_W     = NUM_W + 2;
    localparam int CHUNK     = (RCP_W + 1) / 2;
    localparam int PP_W      = 2 * CHUNK;
    localparam int CROSS_W   = PP_W + 1;
    localparam int FULL_W    = 4 * CHUNK;
    localparam logic [POW_W-1:0] RCP_POW  = POW_W'(1) << RCP_SHIFT;
    localparam logic [POW_W-1:0] RCP_FULL =
        (RCP_POW + POW_W'(RESOLUTION - 1)) / POW_W'(RESOLUTION);
    localparam logic [RCP_W-1:0]       RCP    = RCP_FULL[RCP_W-1:0];
    localparam logic [CHUNK-1:0]       RCP_LO = RCP[CHUNK-1:0];
    localparam logic [RCP_W-CHUNK-1:0] RCP_HI = RCP[RCP_W-1:CHUNK];

    logic [DATA_W-1:0] abs_next;
    logic [DATA_W-1:0] abs_reg;
    logic              abs_valid_reg;

    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_valid_reg;

    logic              num_ovf_next;
    logic [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]  num_reg;
    logic              num_ovf_reg;
    logic              num_valid_reg;

    logic [CHUNK-1:0]       num_lo;
    logic [NUM_W-CHUNK-1:0] num_hi;
    logic [PP_W-1:0]        pp_ll_next;
    logic [PP_W-1:0]        pp_lh_next;
    logic [PP_W-1:0]        pp_hl_next;
    logic [PP_W-1:0]        pp_hh_next;
    logic [PP_W-1:0]        pp_ll_reg;
    logic [PP_W-1:0]        pp_lh_reg;
    logic [PP_W-1:0]        pp_hl_reg;
    logic [PP_W-1:0]        pp_hh_reg;
    logic                   pp_ovf_reg;
    logic                   pp_valid_reg;

    logic [CROSS_W-1:0]     cross_next;
    logic [CROSS_W-1:0]     cross_reg;
    logic [FULL_W-1:0]      outer_reg;
    logic                   cross_ovf_reg;
    logic                   cross_valid_reg;

    logic [FULL_W-1:0]      full_next;
    logic [QUOT_W-1:0]      quot_reg;
    logic                   quot_ovf_reg;
    logic                   quot_valid_reg;

    // magnitude of the two's complement component
    assign abs_next = comp[DATA_W-1] ? (~$unsigned(comp) + DATA_W'(1)) : $unsigned(comp);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_reg <= abs_next;
        end
    end

    // square
    assign prod_next = {{DATA_W{1'b0}}, abs_reg} * {{DATA_W{1'b0}}, abs_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // quotient of 2^32 or more always saturates the sum
    assign num_ovf_next = (prod_reg >= OVF_LIMIT);
    assign num_next     = num_ovf_next ? '0 : prod_reg[NUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg     <= num_next;
            num_ovf_reg <= num_ovf_next;
        end
    end

    // partial products of numerator and reciprocal
    assign num_lo     = num_reg[CHUNK-1:0];
    assign num_hi     = num_reg[NUM_W-1:CHUNK];
    assign pp_ll_next = PP_W'(num_lo) * PP_W'(RCP_LO);
    assign pp_lh_next = PP_W'(num_lo) * PP_W'(RCP_HI);
    assign pp_hl_next = PP_W'(num_hi) * PP_W'(RCP_LO);
    assign pp_hh_next = PP_W'(num_hi) * PP_W'(RCP_HI);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg  <= pp_ll_next;
            pp_lh_reg  <= pp_lh_next;
            pp_hl_reg  <= pp_hl_next;
            pp_hh_reg  <= pp_hh_next;
            pp_ovf_reg <= num_ovf_reg;
        end
    end

    // middle terms share one weight, outer terms do not overlap
    assign cross_next = CROSS_W'(pp_lh_reg) + CROSS_W'(pp_hl_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cross_reg     <= cross_next;
            outer_reg     <= {pp_hh_reg, pp_ll_reg};
            cross_ovf_reg <= pp_ovf_reg;
        end
    end

    // full product, quotient is its top part
    assign full_next = outer_reg + (FULL_W'(cross_reg) << CHUNK);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg     <= full_next[RCP_SHIFT +: QUOT_W];
            quot_ovf_reg <= cross_ovf_reg;
        end
    end

    // valid bits of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_valid_reg   <= 1'b0;
            prod_valid_reg  <= 1'b0;
            num_valid_reg   <= 1'b0;
            pp_valid_reg    <= 1'b0;
            cross_valid_reg <= 1'b0;
            quot_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            abs_valid_reg   <= in_valid;
            prod_valid_reg  <= abs_valid_reg;
            num_valid_reg   <= prod_valid_reg;
            pp_valid_reg    <= num_valid_reg;
            cross_valid_reg <= pp_valid_reg;
            quot_valid_reg  <= cross_valid_reg;
        end
    end

    assign out_valid = quot_valid_reg;
    assign quot      = quot_reg;
    assign ovf       = quot_ovf_reg;

endmodule

`default_nettype wire

[sv/fpvm_isqrt.sv]
// ============================================================================
// fpvm_isqrt
// Pipelined bit-by-bit integer square root with round-up of the result,
// one root step per stage and a final rounding stage.
// ============================================================================
`default_nettype none

module fpvm_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [fpvm_pkg::SUM_W-1:0]    radicand,
    input  wire logic                          in_ovf,
    output logic                               out_valid,
    output logic [fpvm_pkg::ROOT_W-1:0]        root,
    output logic                               out_ovf
);
    import fpvm_pkg::*;

    logic [SUM_W-1:0] rt_rem_reg   [0:ROOT_STEPS-1];
    logic [SUM_W-1:0] rt_root_reg  [0:ROOT_STEPS-1];
    logic             rt_ovf_reg   [0:ROOT_STEPS-1];
    logic             rt_valid_reg [0:ROOT_STEPS-1];

    logic [ROOT_W-1:0] rnd_next;
    logic [ROOT_W-1:0] rnd_reg;
    logic              rnd_ovf_reg;
    logic              rnd_valid_reg;

    // one root step per stage
    for (genvar s = 0; s < ROOT_STEPS; s++)
    begin : g_step
        localparam logic [SUM_W-1:0] BIT = ROOT_TOP >> (2 * s);

        logic [SUM_W-1:0] src_rem;
        logic [SUM_W-1:0] src_root;
        logic             src_ovf;
        logic             src_valid;
        logic [SUM_W:0]   trial;
        logic             take;
        logic [SUM_W-1:0] rt_rem_next;
        logic [SUM_W-1:0] rt_root_next;

        if (s == 0)
        begin : g_first
            assign src_rem   = radicand;
            assign src_root  = '0;
            assign src_ovf   = in_ovf;
            assign src_valid = in_valid;
        end
        else
        begin : g_next
            assign src_rem   = rt_rem_reg[s-1];
            assign src_root  = rt_root_reg[s-1];
            assign src_ovf   = rt_ovf_reg[s-1];
            assign src_valid = rt_valid_reg[s-1];
        end

        always_comb
        begin
            trial = {1'b0, BIT} + {1'b0, src_root};
            take  = (trial <= {1'b0, src_rem});
            if (take)
            begin
                rt_rem_next  = src_rem - trial[SUM_W-1:0];
                rt_root_next = (src_root >> 1) | BIT;
            end
            else
            begin
                rt_rem_next  = src_rem;
                rt_root_next = src_root >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_rem_reg[s]  <= rt_rem_next;
                rt_root_reg[s] <= rt_root_next;
                rt_ovf_reg[s]  <= src_ovf;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                rt_valid_reg[s] <= src_valid;
            end
        end
    end

    // round up when the remainder exceeds the root
    always_comb
    begin
        rnd_next = rt_root_reg[ROOT_STEPS-1][ROOT_W-1:0];
        if (rt_root_reg[ROOT_STEPS-1] < rt_rem_reg[ROOT_STEPS-1])
        begin
            rnd_next = rt_root_reg[ROOT_STEPS-1][ROOT_W-1:0] + ROOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg     <= rnd_next;
            rnd_ovf_reg <= rt_ovf_reg[ROOT_STEPS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rnd_valid_reg <= rt_valid_reg[ROOT_STEPS-1];
        end
    end

    assign out_valid = rnd_valid_reg;
    assign root      = rnd_reg;
    assign out_ovf   = rnd_ovf_reg;

endmodule

`default_nettype wire

[sv/fpvm_out_fifo.sv]
// ============================================================================
// fpvm_out_fifo
// Two-entry result buffer that decouples the pipeline from the output stall.
// ============================================================================
`default_nettype none

module fpvm_out_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire fpvm_pkg::fpvm_item_t  push_item,
    output logic                       full,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output fpvm_pkg::fpvm_item_t       out_item
);
    import fpvm_pkg::*;

    localparam int DEPTH = 2;

    fpvm_item_t mem [0:DEPTH-1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign full      = (cnt_reg == 2'(DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[tb/fixed_point_vector_magnitude_tb.sv]
// ============================================================================
// fixed_point_vector_magnitude_tb
// Streams three-component vectors into the magnitude block under random
// sender gaps and receiver stalls, with one long receiver hold-off, and
// checks every result against a behavioral model of the scaled squares,
// the saturated sum, the rounded square root and the scaling by 100.
// ============================================================================
`default_nettype none

module fixed_point_vector_magnitude_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fpvm_pkg::*;

    localparam int RES        = DEF_RESOLUTION;
    localparam int TAIL_WAIT  = 120;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 1880;

    // scoreboard: expected magnitudes in input order
    class mag_scoreboard;
        fpvm_item_t pending[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // scaled square of one two's complement component
        function logic [63:0] scaled_sq(logic [DATA_W-1:0] comp);
            logic [63:0] mag_abs;
            mag_abs = {32'h0, comp};
            if (comp[DATA_W-1])
                mag_abs = 64'h1_0000_0000 - mag_abs;
            return (mag_abs * mag_abs) / RES;
        endfunction

        // saturated sum, bit-by-bit root with round up, times 100
        function fpvm_item_t vec_magnitude(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                           logic [DATA_W-1:0] z);
            logic [63:0] sum;
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] bit_val;
            fpvm_item_t  res;
            sum = scaled_sq(x) + scaled_sq(y) + scaled_sq(z);
            res.ovf = (sum > 64'hFFFF_FFFF);
            if (res.ovf)
                sum = 64'hFFFF_FFFF;
            rem  = sum;
            root = 64'h0;
            for (int i = 0; i < ROOT_STEPS; i++)
            begin
                bit_val = 64'(ROOT_TOP) >> (2 * i);
                if (bit_val + root <= rem)
                begin
                    rem  = rem - (bit_val + root);
                    root = (root >> 1) | bit_val;
                end
                else
                begin
                    root = root >> 1;
                end
            end
            if (root < rem)
                root = root + 1;
            res.mag = MAG_W'(root * MAG_SCALE);
            return res;
        endfunction

        function void note_input(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                 logic [DATA_W-1:0] z);
            pending.push_back(vec_magnitude(x, y, z));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            fpvm_item_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: mag=%0d ovf=%0b", tdata[MAG_W-1:0], tuser);
                return;
            end
            want = pending.pop_front();
            if (tdata[MAG_W-1:0] !== want.mag || tuser !== want.ovf ||
                tdata[OUT_TDATA_W-1:MAG_W] !== '0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected mag=%0d ovf=%0b, got mag=%0d ovf=%0b pad=%0b",
                             want.mag, want.ovf, tdata[MAG_W-1:0], tuser,
                             tdata[OUT_TDATA_W-1:MAG_W]);
            end
        endfunction
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;   // comp_x, comp_y, comp_z
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;         // magnitude, zero pad
    logic                    m_tuser;         // overflow

    mag_scoreboard sb = new();

    int   tx_max_gap   = 15;
    int   rx_max_stall = 15;
    int   sent_count   = 0;
    logic rx_hold      = 1'b0;
    int   rx_gap       = 0;

    fixed_point_vector_magnitude #(
        .RESOLUTION (RES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always #10 clk = ~clk;

    // receiver: check each result transaction, then stall a random while
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap   = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tuser);
            rx_gap = $urandom_range(0, rx_max_stall);
            m_tready <= (rx_gap == 0) && !rx_hold;
        end
        else if (rx_gap != 0)
        begin
            rx_gap = rx_gap - 1;
            m_tready <= (rx_gap == 0) && !rx_hold;
        end
        else
        begin
            m_tready <= !rx_hold;
        end
    end

    // long receiver hold-off while the sender keeps pushing
    initial
    begin
        wait (sent_count >= 500);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // offer one vector after a random gap and wait for acceptance
    task automatic send_vec(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                            logic [DATA_W-1:0] z);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {z, y, x};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(x, y, z);
        sent_count++;
    endtask

    // one component of a given magnitude with a random sign
    function automatic logic [DATA_W-1:0] signed_comp(int unsigned m);
        return $urandom_range(0, 1) ? DATA_W'(-m) : DATA_W'(m);
    endfunction

    // one component from the corner values or random bits
    function automatic logic [DATA_W-1:0] corner_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h1;
            default: return $urandom;
        endcase
    endfunction

    // random vector mixing ordinary, boundary and noise cases
    task automatic send_random();
        logic [DATA_W-1:0] c[3];
        int                pick;
        pick = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
        begin
            case (pick)
                0, 1, 2, 3: c[k] = signed_comp($urandom_range(0, 2_000_000));
                4, 5:       c[k] = $urandom;
                6:          c[k] = (k == 0) ? signed_comp($urandom_range(6553560, 6553640))
                                            : signed_comp($urandom_range(0, 500));
                7:          c[k] = signed_comp($urandom_range(3783700, 3783870));
                8:          c[k] = signed_comp($urandom_range(0, 300));
                default:    c[k] = corner_comp();
            endcase
        end
        send_vec(c[0], c[1], c[2]);
    endtask

    // stimulus
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, unit and extreme components, rounding and saturation edges
        send_vec(32'd0, 32'd0, 32'd0);
        send_vec(32'd1, 32'd0, 32'd0);
        send_vec(32'hFFFF_FFFF, 32'd0, 32'd0);
        send_vec(32'd10000, 32'd0, 32'd0);
        send_vec(32'd150, 32'd0, 32'd0);
        send_vec(32'd245, 32'd0, 32'd0);
        send_vec(32'd265, 32'd0, 32'd0);
        send_vec(32'd30000, 32'd40000, 32'd0);
        send_vec(-32'sd30000, 32'd40000, -32'sd120000);
        send_vec(32'h8000_0000, 32'd0, 32'd0);
        send_vec(32'd0, 32'h8000_0000, 32'd0);
        send_vec(32'd0, 32'd0, 32'h8000_0000);
        send_vec(32'h7FFF_FFFF, 32'd0, 32'd0);
        send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'd6553599, 32'd0, 32'd0);
        send_vec(32'd6553600, 32'd0, 32'd0);
        send_vec(-32'sd6553600, 32'd0, 32'd0);
        send_vec(32'd0, -32'sd6553599, 32'd0);
        send_vec(32'd3783783, 32'd3783783, 32'd3783783);
        send_vec(32'd3783784, -32'sd3783784, 32'd3783784);
        send_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        send_vec(32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'h5555_5555);

        // random part in phases of different idling
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == 400)
            begin
                tx_max_gap   = 0;
                rx_max_stall = 0;
            end
            else if (i == 800)
            begin
                tx_max_gap   = 15;
                rx_max_stall = 0;
            end
            else if (i == 1200)
            begin
                tx_max_gap   = 0;
                rx_max_stall = 15;
            end
            else if (i == 1600)
            begin
                tx_max_gap   = 15;
                rx_max_stall = 15;
            end
            send_random();
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
